[sv/dtws_pkg.sv]
// constants and helper functions for the swedish-calendar weekday pipeline
// no dependencies; imported by date_to_weekday_swedish_top and its checker

package dtws_pkg;

    localparam int unsigned YearW   = 14;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned WdayW   = 3;
    localparam int unsigned LenW    = 5;
    localparam int unsigned SInW    = 24;
    localparam int unsigned SOutW   = 16;

    // floor(x / 100) == (x * Recip100) >> Recip100Shift for x below 43690
    localparam logic [12:0] Recip100      = 13'd5243;
    localparam int unsigned Recip100Shift = 19;

    localparam logic [YearW-1:0] YearFirst   = 14'd1500;
    localparam logic [YearW-1:0] YearShift1  = 14'd1712;
    localparam logic [YearW-1:0] YearShift2  = 14'd1753;
    localparam logic [YearW-1:0] Rem100Last  = 14'd99;
    localparam logic [YearW-1:0] Rem400Last  = 14'd399;
    localparam logic [WdayW-1:0] WdayFirst   = 3'd3;

    localparam logic [MonthW-1:0] MonFeb = 4'd2;
    localparam logic [MonthW-1:0] MonApr = 4'd4;
    localparam logic [MonthW-1:0] MonJun = 4'd6;
    localparam logic [MonthW-1:0] MonSep = 4'd9;
    localparam logic [MonthW-1:0] MonNov = 4'd11;
    localparam logic [MonthW-1:0] MonDec = 4'd12;

    localparam logic [LenW-1:0] Len17 = 5'd17;
    localparam logic [LenW-1:0] Len28 = 5'd28;
    localparam logic [LenW-1:0] Len29 = 5'd29;
    localparam logic [LenW-1:0] Len30 = 5'd30;
    localparam logic [LenW-1:0] Len31 = 5'd31;

    // 6-bit value mod 7, using 8 == 1 (mod 7)
    function automatic logic [2:0] mod7_6(input logic [5:0] v);
        logic [3:0] b;
        logic [3:0] c;
        b = {1'b0, v[2:0]} + {1'b0, v[5:3]};
        c = (b >= 4'd7) ? (b - 4'd7) : b;
        mod7_6 = (c == 4'd7) ? 3'd0 : c[2:0];
    endfunction

    function automatic logic [2:0] mod7_15(input logic [14:0] v);
        logic [5:0] a;
        a = {3'b0, v[2:0]} + {3'b0, v[5:3]} + {3'b0, v[8:6]}
          + {3'b0, v[11:9]} + {3'b0, v[14:12]};
        mod7_15 = mod7_6(a);
    endfunction

    // days before the month mod 7, february counted as 28 days
    function automatic logic [2:0] month_offset(input logic [MonthW-1:0] m);
        logic [2:0] r;
        unique case (m)
            4'd0:    r = 3'd0;
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd3;
            4'd4:    r = 3'd6;
            4'd5:    r = 3'd1;
            4'd6:    r = 3'd4;
            4'd7:    r = 3'd6;
            4'd8:    r = 3'd2;
            4'd9:    r = 3'd5;
            4'd10:   r = 3'd0;
            4'd11:   r = 3'd3;
            4'd12:   r = 3'd5;
            4'd13:   r = 3'd1;
            4'd14:   r = 3'd4;
            default: r = 3'd0;
        endcase
        month_offset = r;
    endfunction

endpackage

[sv/date_to_weekday_swedish_top.sv]
// date to weekday, month length and leap flag under the historical swedish calendar
// four-stage pipeline; depends on dtws_pkg
//
//  channel | dir | tdata fields (low bit up)
//  s_      | in  | year[13:0] month[17:14] day_of_month[22:18], zero fill to 24
//  m_      | out | weekday[2:0] month_length[7:3] leap_year[8] date_valid[9], zero fill to 16
//
// one item per cycle while m_tready does not stall the output; an accepted item passes
// through stages 1, 2 and 3 and is held in the result register until it leaves
// stage 1 holds the two reciprocal products, stage 2 the year day sum and leap flag,
// stage 3 the year-start weekday and month length, stage 4 the result register
// reset (aresetn low, synchronous) clears the stage valid bits only
// a stall on m_tready holds every stage; s_tready drops only while the result waits

module date_to_weekday_swedish_top
    import dtws_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [SInW-1:0]  s_tdata,   // year, month, day_of_month
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [SOutW-1:0] m_tdata    // weekday, month_length, leap_year, date_valid
);

    logic adv;

    // stage 1
    logic              s1_valid_reg;
    logic [YearW-1:0]  s1_year_reg;
    logic [MonthW-1:0] s1_month_reg;
    logic [DayW-1:0]   s1_day_reg;
    logic [26:0]       s1_p100_reg;
    logic [24:0]       s1_p400_reg;
    logic [YearW-1:0]  s1_n_next;
    logic [26:0]       s1_p100_next;
    logic [24:0]       s1_p400_next;

    // stage 2
    logic              s2_valid_reg;
    logic [MonthW-1:0] s2_month_reg;
    logic [DayW-1:0]   s2_day_reg;
    logic [14:0]       s2_sum_reg;
    logic              s2_early_reg;
    logic              s2_leap_reg;
    logic              s2_y1712_reg;
    logic              s2_y1753_reg;
    logic [14:0]       s2_sum_next;
    logic              s2_leap_next;

    // stage 3
    logic              s3_valid_reg;
    logic [MonthW-1:0] s3_month_reg;
    logic [DayW-1:0]   s3_day_reg;
    logic [WdayW-1:0]  s3_ywd_reg;
    logic [LenW-1:0]   s3_len_reg;
    logic              s3_leap_reg;
    logic [1:0]        s3_feb_extra_reg;
    logic [LenW-1:0]   s3_len_next;
    logic [1:0]        s3_feb_extra_next;

    // stage 4 (output)
    logic              out_valid_reg;
    logic [WdayW-1:0]  out_wday_reg;
    logic [LenW-1:0]   out_len_reg;
    logic              out_leap_reg;
    logic              out_dvalid_reg;
    logic [WdayW-1:0]  out_wday_next;
    logic              out_dvalid_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // stage 1: n = year - 1 and its reciprocal products
    always_comb begin
        s1_n_next    = s_tdata[YearW-1:0] - 14'd1;
        s1_p100_next = 27'(s1_n_next) * 27'(Recip100);
        s1_p400_next = 25'(s1_n_next[YearW-1:2]) * 25'(Recip100);
    end

    // stage 2: gregorian leap count folded into a weekday sum, leap flag
    always_comb begin
        logic [YearW-1:0] n;
        logic [7:0]       q100;
        logic [5:0]       q400;
        logic [YearW-1:0] r100;
        logic [YearW-1:0] r400;
        logic [2:0]       corr;
        n    = s1_year_reg - 14'd1;
        q100 = s1_p100_reg[26:Recip100Shift];
        q400 = s1_p400_reg[24:Recip100Shift];
        r100 = n - 14'(q100 * 14'd100);
        r400 = n - 14'(q400 * 14'd400);
        // 1712 runs one day long, 1753 eleven short (+3 mod 7)
        corr = ((s1_year_reg > YearShift1) ? 3'd1 : 3'd0)
             + ((s1_year_reg > YearShift2) ? 3'd3 : 3'd0);
        // year + n/4 + n/400 - n/100 + 3 + corr, congruent to the year-start weekday
        s2_sum_next = 15'(s1_year_reg) + 15'(n[YearW-1:2]) + 15'(q400)
                    - 15'(q100) + 15'd3 + 15'(corr);
        // divisible by 100 or 400 seen as n's remainder at its top value
        s2_leap_next = (s1_year_reg == YearFirst)
                    || ((s1_year_reg[1:0] == 2'd0)
                        && ((r100 != Rem100Last) || (r400 == Rem400Last)));
    end

    // stage 3: month length, february's length and its shift of later months
    always_comb begin
        logic [LenW-1:0] feb_len;
        priority if (s2_y1712_reg) begin
            feb_len           = Len30;
            s3_feb_extra_next = 2'd2;
        end else if (s2_y1753_reg) begin
            feb_len           = Len17;
            s3_feb_extra_next = 2'd3;
        end else if (s2_leap_reg) begin
            feb_len           = Len29;
            s3_feb_extra_next = 2'd1;
        end else begin
            feb_len           = Len28;
            s3_feb_extra_next = 2'd0;
        end
        priority if (s2_month_reg == MonFeb) begin
            s3_len_next = feb_len;
        end else if (s2_month_reg == MonApr || s2_month_reg == MonJun
                  || s2_month_reg == MonSep || s2_month_reg == MonNov) begin
            s3_len_next = Len30;
        end else begin
            s3_len_next = Len31;
        end
    end

    // stage 4: add month offset and day, final mod 7, range check
    always_comb begin
        logic [5:0] tot;
        logic [1:0] fx;
        fx  = (s3_month_reg > MonFeb) ? s3_feb_extra_reg : 2'd0;
        tot = 6'(s3_ywd_reg) + 6'(month_offset(s3_month_reg)) + 6'(fx)
            + 6'(s3_day_reg) + 6'd6;
        out_wday_next   = mod7_6(tot);
        out_dvalid_next = (s3_month_reg != 4'd0) && (s3_month_reg <= MonDec)
                       && (s3_day_reg != 5'd0) && (s3_day_reg <= s3_len_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= s_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_year_reg      <= s_tdata[YearW-1:0];
            s1_month_reg     <= s_tdata[YearW+MonthW-1:YearW];
            s1_day_reg       <= s_tdata[YearW+MonthW+DayW-1:YearW+MonthW];
            s1_p100_reg      <= s1_p100_next;
            s1_p400_reg      <= s1_p400_next;

            s2_month_reg     <= s1_month_reg;
            s2_day_reg       <= s1_day_reg;
            s2_sum_reg       <= s2_sum_next;
            s2_early_reg     <= (s1_year_reg <= YearFirst);
            s2_leap_reg      <= s2_leap_next;
            s2_y1712_reg     <= (s1_year_reg == YearShift1);
            s2_y1753_reg     <= (s1_year_reg == YearShift2);

            s3_month_reg     <= s2_month_reg;
            s3_day_reg       <= s2_day_reg;
            s3_ywd_reg       <= s2_early_reg ? WdayFirst : mod7_15(s2_sum_reg);
            s3_len_reg       <= s3_len_next;
            s3_leap_reg      <= s2_leap_reg;
            s3_feb_extra_reg <= s3_feb_extra_next;

            out_wday_reg     <= out_wday_next;
            out_len_reg      <= s3_len_reg;
            out_leap_reg     <= s3_leap_reg;
            out_dvalid_reg   <= out_dvalid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_dvalid_reg, out_leap_reg, out_len_reg, out_wday_reg};

endmodule

[sv/dtws_checker.sv]
// port-level checks for date_to_weekday_swedish_top
// depends on dtws_pkg; bound to the top level at the end of this file

module dtws_checker
    import dtws_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [SOutW-1:0] m_tdata
);

    // a held result keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side only stalls behind a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // an accepted item is on the output when nothing stalls while it passes the stages
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("item lost in the pipeline");

    // weekday below 7, month length at least 17, a 29-day month only in a leap year
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] != 3'd7) && (m_tdata[7:3] >= Len17)
                  && ((m_tdata[7:3] != Len29) || m_tdata[8]))
        else $error("result fields out of range");

endmodule

bind date_to_weekday_swedish_top dtws_checker u_dtws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
